>>> sv/esc_pkg.sv
`timescale 1ns / 1ps
package esc_pkg;

  localparam logic [19:0] SKIP_RAW20 = 20'h80000;
  localparam logic [15:0] SKIP_RAW16 = 16'h8000;
  localparam logic [20:0] PRESS_RAW_BASE = 21'd1048576;
  localparam logic [63:0] T_FINE_PRESS = 64'd128000;
  localparam logic [31:0] T_FINE_HUM = 32'd76800;
  localparam logic [63:0] PRESS_OFFSET = 64'd140737488355328;
  localparam logic [63:0] PRESS_SCALE = 64'd3125;
  localparam logic [31:0] HUM_MAX = 32'd419430400;
  localparam logic [16:0] HUM_OUT_MAX = 17'd102400;
  localparam int DIV_CELLS = 64;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_SKIP = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
    logic [7:0]  h1;
    logic [15:0] h2;
    logic [7:0]  h3;
    logic [11:0] h4;
    logic [11:0] h5;
    logic [7:0]  h6;
  } cal_t;

  // partial products of a 64-bit product taken mod 2^64
  typedef struct packed {
    logic [63:0] lo;
    logic [31:0] mid;
  } pp_t;

  // fields that ride along the quotient chain
  typedef struct packed {
    logic        skip;
    logic        zero;
    logic        neg;
    logic [31:0] fine_temp;
    logic [23:0] temp_centi;
    logic [31:0] hum_x3;
    logic [31:0] hum_g;
  } side_t;

  typedef struct packed {
    logic        v;
    logic [63:0] rem;
    logic [63:0] quo;
    logic [63:0] dvsr;
    side_t       side;
  } cell_t;

  typedef struct packed {
    logic        v;
    logic [31:0] fine_temp;
    logic [23:0] temp_centi;
    logic [31:0] press;
    logic [16:0] hum;
    logic [1:0]  status;
  } res_t;

  function automatic logic [63:0] sx16(logic [15:0] x);
    sx16 = 64'($signed(x));
  endfunction

  function automatic logic [31:0] mul32(logic [31:0] a, logic [31:0] b);
    mul32 = a * b;
  endfunction

  function automatic pp_t mul_pp(logic [63:0] a, logic [63:0] b);
    logic [31:0] c1;
    logic [31:0] c2;
    mul_pp.lo = {32'b0, a[31:0]} * {32'b0, b[31:0]};
    c1 = a[31:0] * b[63:32];
    c2 = a[63:32] * b[31:0];
    mul_pp.mid = c1 + c2;
  endfunction

  function automatic logic [63:0] mul_fin(pp_t p);
    mul_fin = p.lo + {p.mid, 32'b0};
  endfunction

  // signed shift that rounds toward zero
  function automatic logic [31:0] sdiv32(logic [31:0] x, int unsigned k);
    logic [31:0] b;
    b = x[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
    sdiv32 = 32'($signed(x + b) >>> k);
  endfunction

  function automatic logic [63:0] sdiv64(logic [63:0] x, int unsigned k);
    logic [63:0] b;
    b = x[63] ? ((64'd1 << k) - 64'd1) : 64'd0;
    sdiv64 = 64'($signed(x + b) >>> k);
  endfunction

endpackage

>>> sv/esc_front.sv
`timescale 1ns / 1ps
module esc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_v,
  input  logic [19:0]        raw_t,
  input  logic [19:0]        raw_p,
  input  logic [15:0]        raw_h,
  input  esc_pkg::cal_t      cal,
  output esc_pkg::cell_t     d_out
);

  typedef struct packed {
    logic        v;
    logic        skip;
    logic [20:0] q4a;
    logic [15:0] adch;
    logic [31:0] tf;
    logic [23:0] tc;
  } fcarry_t;

  fcarry_t carry_r [0:14];
  fcarry_t carry_nxt [1:14];

  logic signed [18:0] v1a_r;
  logic signed [17:0] v2a_r;
  logic [31:0] m1_r, sq_r, v1b_r, sqd_r, v1d_r, m3_r;
  logic [63:0] q1_r;
  logic [31:0] tcw_r, x1_r;
  esc_pkg::pp_t ppq_r, pp5_r, pp2_r, pp6_r, pp3_r, ppp1_r, ppn_r;
  logic [31:0] hx4_r, hx2_r, hx3_r, base_r;
  logic [63:0] sq64_r, m5_r, m2_r, s5_r, s2i_r, a6_r, a3_r, s5j_r, s2j_r;
  logic [63:0] q2_r, d3_r, s2k_r, q1b_r, n_r, pr_r, num_r, den_r, numo_r;
  logic [31:0] x5a_r, y2_r, y3_r, z_r, x5i_r, x4_r, x5j_r, w_r, x5k_r;
  logic [31:0] x2c_r, x5l_r, x3m_r, e_r, x3n_r, f_r, x3o_r;
  esc_pkg::cell_t out_r;

  // advance the side carry, dropping in fine and centi temperature where they land
  always_comb begin
    for (int i = 1; i < 15; i++) carry_nxt[i] = carry_r[i-1];
    carry_nxt[4].tf = v1d_r + esc_pkg::sdiv32(m3_r, 14);
    carry_nxt[6].tc = 24'(esc_pkg::sdiv32(tcw_r, 8));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 15; i++) carry_r[i].v <= 1'b0;
      out_r.v <= 1'b0;
    end else if (en) begin
      carry_r[0].v    <= in_v;
      carry_r[0].skip <= (raw_p == esc_pkg::SKIP_RAW20) || (raw_t == esc_pkg::SKIP_RAW20) ||
                         (raw_h == esc_pkg::SKIP_RAW16);
      carry_r[0].q4a  <= esc_pkg::PRESS_RAW_BASE - {1'b0, raw_p};
      carry_r[0].adch <= raw_h;
      for (int i = 1; i < 15; i++) carry_r[i] <= carry_nxt[i];

      // temperature
      v1a_r <= $signed({2'b0, raw_t[19:3]}) - $signed({2'b0, cal.t1, 1'b0});
      v2a_r <= $signed({2'b0, raw_t[19:4]}) - $signed({2'b0, cal.t1});
      m1_r  <= esc_pkg::mul32(32'(v1a_r), 32'($signed(cal.t2)));
      sq_r  <= esc_pkg::mul32(32'(v2a_r), 32'(v2a_r));
      v1b_r <= esc_pkg::sdiv32(m1_r, 11);
      sqd_r <= esc_pkg::sdiv32(sq_r, 12);
      v1d_r <= v1b_r;
      m3_r  <= esc_pkg::mul32(sqd_r, 32'($signed(cal.t3)));

      q1_r  <= 64'($signed(carry_r[4].tf)) - esc_pkg::T_FINE_PRESS;
      tcw_r <= (carry_r[4].tf << 2) + carry_r[4].tf + 32'd128;
      x1_r  <= carry_r[4].tf - esc_pkg::T_FINE_HUM;

      // pressure: divisor and numerator
      ppq_r <= esc_pkg::mul_pp(q1_r, q1_r);
      pp5_r <= esc_pkg::mul_pp(q1_r, esc_pkg::sx16(cal.p5));
      pp2_r <= esc_pkg::mul_pp(q1_r, esc_pkg::sx16(cal.p2));

      sq64_r <= esc_pkg::mul_fin(ppq_r);
      m5_r   <= esc_pkg::mul_fin(pp5_r);
      m2_r   <= esc_pkg::mul_fin(pp2_r);

      pp6_r <= esc_pkg::mul_pp(sq64_r, esc_pkg::sx16(cal.p6));
      pp3_r <= esc_pkg::mul_pp(sq64_r, esc_pkg::sx16(cal.p3));
      s5_r  <= m5_r << 17;
      s2i_r <= m2_r << 12;

      a6_r  <= esc_pkg::mul_fin(pp6_r);
      a3_r  <= esc_pkg::mul_fin(pp3_r);
      s5j_r <= s5_r;
      s2j_r <= s2i_r;

      q2_r  <= a6_r + s5j_r + (esc_pkg::sx16(cal.p4) << 35);
      d3_r  <= esc_pkg::sdiv64(a3_r, 8);
      s2k_r <= s2j_r;

      q1b_r <= d3_r + s2k_r + esc_pkg::PRESS_OFFSET;
      n_r   <= ({43'b0, carry_r[10].q4a} << 31) - q2_r;

      ppp1_r <= esc_pkg::mul_pp(q1b_r, {48'b0, cal.p1});
      ppn_r  <= esc_pkg::mul_pp(n_r, esc_pkg::PRESS_SCALE);

      pr_r  <= esc_pkg::mul_fin(ppp1_r);
      num_r <= esc_pkg::mul_fin(ppn_r);

      den_r  <= esc_pkg::sdiv64(pr_r, 33);
      numo_r <= num_r;

      // humidity
      hx4_r  <= esc_pkg::mul32(32'($signed(cal.h5)), x1_r);
      hx2_r  <= esc_pkg::mul32(x1_r, 32'($signed(cal.h6)));
      hx3_r  <= esc_pkg::mul32(x1_r, {24'b0, cal.h3});
      base_r <= {2'b0, carry_r[5].adch, 14'b0} - {cal.h4, 20'b0};

      x5a_r <= esc_pkg::sdiv32(base_r - hx4_r + 32'd16384, 15);
      y2_r  <= esc_pkg::sdiv32(hx2_r, 10);
      y3_r  <= esc_pkg::sdiv32(hx3_r, 11) + 32'd32768;

      z_r   <= esc_pkg::mul32(y2_r, y3_r);
      x5i_r <= x5a_r;
      x4_r  <= esc_pkg::sdiv32(z_r, 10) + 32'd2097152;
      x5j_r <= x5i_r;
      w_r   <= esc_pkg::mul32(x4_r, 32'($signed(cal.h2)));
      x5k_r <= x5j_r;
      x2c_r <= esc_pkg::sdiv32(w_r + 32'd8192, 14);
      x5l_r <= x5k_r;
      x3m_r <= esc_pkg::mul32(x5l_r, x2c_r);
      e_r   <= esc_pkg::sdiv32(x3m_r, 15);
      x3n_r <= x3m_r;
      f_r   <= esc_pkg::mul32(e_r, e_r);
      x3o_r <= x3n_r;

      // load the head of the quotient chain with magnitudes
      out_r.v    <= carry_r[14].v;
      out_r.rem  <= 64'd0;
      out_r.quo  <= numo_r[63] ? -numo_r : numo_r;
      out_r.dvsr <= den_r[63] ? -den_r : den_r;
      out_r.side.neg        <= numo_r[63] ^ den_r[63];
      out_r.side.zero       <= (den_r == 64'd0);
      out_r.side.skip       <= carry_r[14].skip;
      out_r.side.fine_temp  <= carry_r[14].tf;
      out_r.side.temp_centi <= carry_r[14].tc;
      out_r.side.hum_x3     <= x3o_r;
      out_r.side.hum_g      <= esc_pkg::sdiv32(f_r, 7);
    end
  end

  assign d_out = out_r;

endmodule

>>> sv/esc_div_cell.sv
`timescale 1ns / 1ps
module esc_div_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  esc_pkg::cell_t d_in,
  output esc_pkg::cell_t d_out
);

  logic [64:0] trial;
  logic [64:0] diff;
  logic        ge;
  esc_pkg::cell_t cell_nxt;
  esc_pkg::cell_t cell_r;

  // one restoring step: bring down the next dividend bit, subtract if it fits
  always_comb begin
    trial = {d_in.rem, d_in.quo[63]};
    diff  = trial - {1'b0, d_in.dvsr};
    ge    = (trial >= {1'b0, d_in.dvsr});
    cell_nxt      = d_in;
    cell_nxt.rem  = ge ? diff[63:0] : trial[63:0];
    cell_nxt.quo  = {d_in.quo[62:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.v <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign d_out = cell_r;

endmodule

>>> sv/esc_back.sv
`timescale 1ns / 1ps
module esc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  esc_pkg::cell_t d_in,
  input  esc_pkg::cal_t  cal,
  output esc_pkg::res_t  res
);

  typedef struct packed {
    logic        v;
    logic        skip;
    logic        zero;
    logic [31:0] fine_temp;
    logic [23:0] temp_centi;
    logic [31:0] hx3;
    logic [31:0] hg;
    logic [16:0] hum;
  } bcarry_t;

  bcarry_t carry_r [0:8];
  bcarry_t carry_nxt [1:8];

  logic [63:0] q4_r, a_r, q4r_r, m8_r, as_r, q4s_r, b_r, q2d_r, at_r, q4t_r;
  logic [63:0] q2du_r, q4u_r, c_r, q2dv_r, q4v_r, q1d_r, q2dw_r, q4w_r, sum_r, d_r;
  esc_pkg::pp_t pp8_r, pp9_r, ppb_r;
  logic [31:0] hm_r, x5_r, x5c;
  logic [63:0] r_fin;
  logic [31:0] press_sat;
  esc_pkg::res_t res_r;

  always_comb begin
    if (x5_r[31]) x5c = 32'd0;
    else if (x5_r > esc_pkg::HUM_MAX) x5c = esc_pkg::HUM_MAX;
    else x5c = x5_r;
    r_fin = d_r + (esc_pkg::sx16(cal.p7) << 4);
    if (r_fin[63]) press_sat = 32'd0;
    else if (|r_fin[62:32]) press_sat = 32'hFFFF_FFFF;
    else press_sat = r_fin[31:0];
    // advance the side carry, dropping in the humidity where it lands
    for (int i = 1; i < 9; i++) carry_nxt[i] = carry_r[i-1];
    carry_nxt[3].hum = 17'(x5c >> 12);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) carry_r[i].v <= 1'b0;
      res_r.v <= 1'b0;
    end else if (en) begin
      carry_r[0].v          <= d_in.v;
      carry_r[0].skip       <= d_in.side.skip;
      carry_r[0].zero       <= d_in.side.zero;
      carry_r[0].fine_temp  <= d_in.side.fine_temp;
      carry_r[0].temp_centi <= d_in.side.temp_centi;
      carry_r[0].hx3        <= d_in.side.hum_x3;
      carry_r[0].hg         <= d_in.side.hum_g;
      for (int i = 1; i < 9; i++) carry_r[i] <= carry_nxt[i];

      q4_r <= d_in.side.neg ? -d_in.quo : d_in.quo;

      a_r   <= esc_pkg::sdiv64(q4_r, 13);
      pp8_r <= esc_pkg::mul_pp(q4_r, esc_pkg::sx16(cal.p8));
      q4r_r <= q4_r;
      hm_r  <= esc_pkg::mul32(carry_r[0].hg, {24'b0, cal.h1});

      pp9_r <= esc_pkg::mul_pp(esc_pkg::sx16(cal.p9), a_r);
      m8_r  <= esc_pkg::mul_fin(pp8_r);
      as_r  <= a_r;
      q4s_r <= q4r_r;
      x5_r  <= carry_r[1].hx3 - esc_pkg::sdiv32(hm_r, 4);

      b_r   <= esc_pkg::mul_fin(pp9_r);
      q2d_r <= esc_pkg::sdiv64(m8_r, 19);
      at_r  <= as_r;
      q4t_r <= q4s_r;

      ppb_r  <= esc_pkg::mul_pp(b_r, at_r);
      q2du_r <= q2d_r;
      q4u_r  <= q4t_r;

      c_r    <= esc_pkg::mul_fin(ppb_r);
      q2dv_r <= q2du_r;
      q4v_r  <= q4u_r;

      q1d_r  <= esc_pkg::sdiv64(c_r, 25);
      q2dw_r <= q2dv_r;
      q4w_r  <= q4v_r;

      sum_r <= q4w_r + q1d_r + q2dw_r;
      d_r   <= esc_pkg::sdiv64(sum_r, 8);

      res_r.v <= carry_r[8].v;
      if (carry_r[8].skip) begin
        res_r.fine_temp  <= 32'd0;
        res_r.temp_centi <= 24'd0;
        res_r.press      <= 32'd0;
        res_r.hum        <= 17'd0;
        res_r.status     <= esc_pkg::ST_SKIP;
      end else begin
        res_r.fine_temp  <= carry_r[8].fine_temp;
        res_r.temp_centi <= carry_r[8].temp_centi;
        res_r.press      <= carry_r[8].zero ? 32'd0 : press_sat;
        res_r.hum        <= carry_r[8].hum;
        res_r.status     <= carry_r[8].zero ? esc_pkg::ST_ZERO : esc_pkg::ST_OK;
      end
    end
  end

  assign res = res_r;

endmodule

>>> sv/env_sensor_compensation_core.sv
`timescale 1ns / 1ps
// Throughput: one reading per clock cycle, sustained while the output is not stalled.
// Path: a reading accepted at an edge reaches out_valid through 16 front stages,
//   64 quotient cells and 10 back stages; a stall holds every stage.
// The 64-cell quotient chain, one quotient bit per cell, sets the latency.
// Reset: synchronous, active-low rst_n clears all valid flags, the input skid
//   and the calibration registers (all to 0); no clearing pass is needed.
module env_sensor_compensation_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [19:0] in_raw_temp,
  input  logic [19:0] in_raw_press,
  input  logic [15:0] in_raw_hum,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_fine_temp,
  output logic [23:0] out_temp_centi,
  output logic [31:0] out_press_q24_8,
  output logic [16:0] out_hum_q22_10,
  output logic [1:0]  out_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  // register slots, 8 bytes apart
  localparam logic [2:0] REG_TEMP_CAL    = 3'd0;
  localparam logic [2:0] REG_PRESS_CAL_A = 3'd1;
  localparam logic [2:0] REG_PRESS_CAL_B = 3'd2;
  localparam logic [2:0] REG_PRESS_CAL_C = 3'd3;
  localparam logic [2:0] REG_HUM_CAL     = 3'd4;

  logic [47:0] temp_cal_r;
  logic [63:0] press_cal_a_r, press_cal_b_r, hum_cal_r;
  logic [15:0] press_cal_c_r;
  esc_pkg::cal_t cal;

  logic        skid_v_r;
  logic [19:0] skid_t_r, skid_p_r;
  logic [15:0] skid_h_r;
  logic        accept, en;
  logic        f_v;
  logic [19:0] f_t, f_p;
  logic [15:0] f_h;

  esc_pkg::cell_t chain [0:esc_pkg::DIV_CELLS];
  esc_pkg::res_t  res;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_cal_r    <= '0;
      press_cal_a_r <= '0;
      press_cal_b_r <= '0;
      press_cal_c_r <= '0;
      hum_cal_r     <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[5:3])
        REG_TEMP_CAL:    temp_cal_r    <= pwdata[47:0];
        REG_PRESS_CAL_A: press_cal_a_r <= pwdata;
        REG_PRESS_CAL_B: press_cal_b_r <= pwdata;
        REG_PRESS_CAL_C: press_cal_c_r <= pwdata[15:0];
        REG_HUM_CAL:     hum_cal_r     <= pwdata;
        default: ;  // drop writes outside the map
      endcase
    end
  end

  always_comb begin
    case (paddr[5:3])
      REG_TEMP_CAL:    prdata = {16'b0, temp_cal_r};
      REG_PRESS_CAL_A: prdata = press_cal_a_r;
      REG_PRESS_CAL_B: prdata = press_cal_b_r;
      REG_PRESS_CAL_C: prdata = {48'b0, press_cal_c_r};
      REG_HUM_CAL:     prdata = hum_cal_r;
      default:         prdata = 64'd0;
    endcase
  end

  // unpack the calibration words into coefficients
  assign cal.t1 = temp_cal_r[15:0];
  assign cal.t2 = temp_cal_r[31:16];
  assign cal.t3 = temp_cal_r[47:32];
  assign cal.p1 = press_cal_a_r[15:0];
  assign cal.p2 = press_cal_a_r[31:16];
  assign cal.p3 = press_cal_a_r[47:32];
  assign cal.p4 = press_cal_a_r[63:48];
  assign cal.p5 = press_cal_b_r[15:0];
  assign cal.p6 = press_cal_b_r[31:16];
  assign cal.p7 = press_cal_b_r[47:32];
  assign cal.p8 = press_cal_b_r[63:48];
  assign cal.p9 = press_cal_c_r;
  assign cal.h1 = hum_cal_r[7:0];
  assign cal.h2 = hum_cal_r[23:8];
  assign cal.h3 = hum_cal_r[31:24];
  assign cal.h4 = hum_cal_r[43:32];
  assign cal.h5 = hum_cal_r[55:44];
  assign cal.h6 = hum_cal_r[63:56];

  // ---------------- flow control ----------------
  // The whole pipe advances unless a finished beat is waiting at the output.
  // A one-beat skid at the input keeps in_ready off that stall path.
  assign en       = !res.v || out_ready;
  assign in_ready = !skid_v_r;
  assign accept   = in_valid && !skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else if (en) begin
      skid_v_r <= 1'b0;
    end else if (accept) begin
      skid_v_r <= 1'b1;
    end
  end

  // hold the stalled beat in the skid
  always_ff @(posedge clk) begin
    if (accept && !en) begin
      skid_t_r <= in_raw_temp;
      skid_p_r <= in_raw_press;
      skid_h_r <= in_raw_hum;
    end
  end

  // skid beat goes first, else the live input
  assign f_v = skid_v_r || accept;
  assign f_t = skid_v_r ? skid_t_r : in_raw_temp;
  assign f_p = skid_v_r ? skid_p_r : in_raw_press;
  assign f_h = skid_v_r ? skid_h_r : in_raw_hum;

  // ---------------- datapath ----------------
  // front: temperature, humidity, pressure numerator and divisor
  esc_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (f_v),
    .raw_t (f_t),
    .raw_p (f_p),
    .raw_h (f_h),
    .cal   (cal),
    .d_out (chain[0])
  );

  // quotient chain: one bit per cell, MSB first
  for (genvar i = 0; i < esc_pkg::DIV_CELLS; i++) begin : g_cell
    esc_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_in  (chain[i]),
      .d_out (chain[i+1])
    );
  end

  // back: pressure correction, saturation, humidity clamp, status
  esc_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .d_in  (chain[esc_pkg::DIV_CELLS]),
    .cal   (cal),
    .res   (res)
  );

  assign out_valid       = res.v;
  assign out_fine_temp   = res.fine_temp;
  assign out_temp_centi  = res.temp_centi;
  assign out_press_q24_8 = res.press;
  assign out_hum_q22_10  = res.hum;
  assign out_status      = res.status;

endmodule

>>> sv/esc_checker.sv
`timescale 1ns / 1ps
module esc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_fine_temp,
  input logic [23:0] out_temp_centi,
  input logic [31:0] out_press_q24_8,
  input logic [16:0] out_hum_q22_10,
  input logic [1:0]  out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_fine_temp) &&
      $stable(out_press_q24_8) && $stable(out_hum_q22_10) && $stable(out_status))
    else $error("output beat changed while stalled");

  a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == esc_pkg::ST_SKIP |->
      out_fine_temp == 32'd0 && out_temp_centi == 24'd0 &&
      out_press_q24_8 == 32'd0 && out_hum_q22_10 == 17'd0)
    else $error("skipped reading carries nonzero fields");

  a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == esc_pkg::ST_ZERO |-> out_press_q24_8 == 32'd0)
    else $error("zero divisor gave nonzero pressure");

  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hum_q22_10 <= esc_pkg::HUM_OUT_MAX && out_status != 2'd3)
    else $error("humidity or status out of range");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset did not clear the pipe");

endmodule

bind env_sensor_compensation_core esc_checker u_esc_checker (.*);
